>>> design/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Types and constants shared by the door controller modules.
// ----------------------------------------------------------------------------
package mdc_pkg;

  typedef enum logic [1:0] {
    MODE_CLOSED   = 2'd0,
    MODE_OPEN     = 2'd1,
    MODE_RISING   = 2'd2,
    MODE_LOWERING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ENCODER = 3'd1,
    OP_OPEN    = 3'd2,
    OP_CLOSE   = 3'd3,
    OP_HOME    = 3'd4,
    OP_SET_POS = 3'd5
  } opcode_t;

  localparam logic [2:0] REG_OPEN_HEIGHT = 3'd0;
  localparam logic [2:0] REG_STEPS_CM    = 3'd1;
  localparam logic [2:0] REG_TIMEOUT     = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED   = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED   = 3'd4;
  localparam logic [2:0] REG_LIMIT_SW    = 3'd5;
  localparam logic [2:0] REG_REVERSE     = 3'd6;

  localparam logic [6:0]  RAMP_LIMIT    = 7'd120;
  localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
  localparam logic [23:0] POS_MAX       = 24'h7FFFFF;
  localparam logic [23:0] POS_MIN       = 24'h800000;

  typedef struct packed {
    logic [7:0]  min_speed;
    logic [7:0]  max_speed;
    logic        limit_switch_present;
    logic        reverse_direction;
    logic [19:0] bottom;
    logic [21:0] timeout_load;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] position;
    logic [1:0]         door_state;
    logic [7:0]         pwm_duty;
    logic               bridge_enable;
    logic               bridge_in2;
    logic               bridge_in1;
  } result_t;

endpackage

>>> design/mdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdc_cfg_regs
// Configuration register file with registered travel and timeout products.
// ----------------------------------------------------------------------------
module mdc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [11:0]   wr_data,
  output mdc_pkg::cfg_t cfg
);

  logic [9:0]  open_height_cm;
  logic [9:0]  steps_per_cm;
  logic [11:0] timeout_seconds;
  logic [7:0]  min_speed;
  logic [7:0]  max_speed;
  logic        limit_switch_present;
  logic        reverse_direction;
  logic [19:0] bottom;
  logic [21:0] timeout_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_height_cm       <= '0;
      steps_per_cm         <= '0;
      timeout_seconds      <= '0;
      min_speed            <= '0;
      max_speed            <= 8'hFF;
      limit_switch_present <= 1'b0;
      reverse_direction    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        mdc_pkg::REG_OPEN_HEIGHT: open_height_cm       <= wr_data[9:0];
        mdc_pkg::REG_STEPS_CM:    steps_per_cm         <= wr_data[9:0];
        mdc_pkg::REG_TIMEOUT:     timeout_seconds      <= wr_data;
        mdc_pkg::REG_MIN_SPEED:   min_speed            <= wr_data[7:0];
        mdc_pkg::REG_MAX_SPEED:   max_speed            <= wr_data[7:0];
        mdc_pkg::REG_LIMIT_SW:    limit_switch_present <= wr_data[0];
        mdc_pkg::REG_REVERSE:     reverse_direction    <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  // registered products; the user must write only while idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      bottom       <= '0;
      timeout_load <= '0;
    end else begin
      bottom       <= 20'(open_height_cm) * 20'(steps_per_cm);
      timeout_load <= 22'(timeout_seconds) * 22'(mdc_pkg::MS_PER_SECOND);
    end
  end

  assign cfg.min_speed            = min_speed;
  assign cfg.max_speed            = max_speed;
  assign cfg.limit_switch_present = limit_switch_present;
  assign cfg.reverse_direction    = reverse_direction;
  assign cfg.bottom               = bottom;
  assign cfg.timeout_load         = timeout_load;

endmodule

>>> design/mdc_core.sv
// ----------------------------------------------------------------------------
// mdc_core
// Door state, position, ramp and timeout update, one event per cycle while fire is high.
// ----------------------------------------------------------------------------
module mdc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [2:0]         opcode,
  input  logic               limit_not_reached,
  input  logic signed [23:0] position_value,
  input  mdc_pkg::cfg_t      cfg,
  output mdc_pkg::result_t   result
);

  mdc_pkg::mode_t     door_mode, door_mode_next;
  logic signed [23:0] position_count, position_count_next;
  logic [7:0]         speed, speed_next;
  logic [6:0]         ramp_ms, ramp_ms_next;
  logic [21:0]        timeout_ms_left, timeout_ms_left_next;
  logic               homing, homing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_mode       <= mdc_pkg::MODE_CLOSED;
      position_count  <= '0;
      speed           <= '0;
      ramp_ms         <= '0;
      timeout_ms_left <= '0;
      homing          <= 1'b0;
    end else if (fire) begin
      door_mode       <= door_mode_next;
      position_count  <= position_count_next;
      speed           <= speed_next;
      ramp_ms         <= ramp_ms_next;
      timeout_ms_left <= timeout_ms_left_next;
      homing          <= homing_next;
    end
  end

  always_comb begin
    logic       moving;
    logic [6:0] ramp_inc;
    logic       expired;
    moving               = (door_mode == mdc_pkg::MODE_RISING) ||
                           (door_mode == mdc_pkg::MODE_LOWERING);
    ramp_inc             = ramp_ms + 7'd1;
    door_mode_next       = door_mode;
    position_count_next  = position_count;
    speed_next           = speed;
    ramp_ms_next         = ramp_ms;
    timeout_ms_left_next = timeout_ms_left;
    homing_next          = homing;

    case (opcode)
      mdc_pkg::OP_TICK: begin
        if (door_mode == mdc_pkg::MODE_RISING && timeout_ms_left != '0)
          timeout_ms_left_next = timeout_ms_left - 22'd1;
        if (moving && speed < cfg.max_speed) begin
          if (ramp_inc > mdc_pkg::RAMP_LIMIT) begin
            speed_next   = speed + 8'd1;
            ramp_ms_next = '0;
          end else begin
            ramp_ms_next = ramp_inc;
          end
        end
      end
      mdc_pkg::OP_ENCODER: begin
        if (door_mode == mdc_pkg::MODE_RISING || door_mode == mdc_pkg::MODE_OPEN) begin
          if (position_count != mdc_pkg::POS_MIN)
            position_count_next = position_count - 24'sd1;
        end else if (position_count != mdc_pkg::POS_MAX) begin
          position_count_next = position_count + 24'sd1;
        end
      end
      mdc_pkg::OP_OPEN: begin
        if (door_mode == mdc_pkg::MODE_CLOSED) begin
          door_mode_next       = mdc_pkg::MODE_RISING;
          speed_next           = cfg.min_speed;
          ramp_ms_next         = '0;
          timeout_ms_left_next = cfg.timeout_load;
          homing_next          = 1'b0;
        end
      end
      mdc_pkg::OP_CLOSE: begin
        if (door_mode == mdc_pkg::MODE_OPEN) begin
          door_mode_next = mdc_pkg::MODE_LOWERING;
          speed_next     = cfg.min_speed;
          ramp_ms_next   = '0;
        end
      end
      mdc_pkg::OP_HOME: begin
        door_mode_next       = mdc_pkg::MODE_RISING;
        speed_next           = cfg.min_speed;
        ramp_ms_next         = '0;
        timeout_ms_left_next = cfg.timeout_load;
        homing_next          = 1'b1;
      end
      mdc_pkg::OP_SET_POS: position_count_next = position_value;
      default: begin
      end
    endcase

    // stop checks run after every event
    expired = (timeout_ms_left_next == '0);
    if (door_mode_next == mdc_pkg::MODE_RISING) begin
      if (homing_next || cfg.limit_switch_present) begin
        if (!limit_not_reached || expired) begin
          door_mode_next      = mdc_pkg::MODE_OPEN;
          position_count_next = '0;
          homing_next         = 1'b0;
        end
      end else if (position_count_next <= 24'sd0 || expired) begin
        door_mode_next = mdc_pkg::MODE_OPEN;
      end
    end else if (door_mode_next == mdc_pkg::MODE_LOWERING) begin
      if (position_count_next >= $signed({4'b0000, cfg.bottom}))
        door_mode_next = mdc_pkg::MODE_CLOSED;
    end
  end

  always_comb begin
    result.position      = position_count_next;
    result.door_state    = door_mode_next;
    result.bridge_in1    = 1'b1;
    result.bridge_in2    = 1'b1;
    result.bridge_enable = 1'b0;
    result.pwm_duty      = '0;
    if (door_mode_next == mdc_pkg::MODE_RISING) begin
      result.bridge_in1    = !cfg.reverse_direction;
      result.bridge_in2    = cfg.reverse_direction;
      result.bridge_enable = 1'b1;
      result.pwm_duty      = speed_next;
    end else if (door_mode_next == mdc_pkg::MODE_LOWERING) begin
      result.bridge_in1    = cfg.reverse_direction;
      result.bridge_in2    = !cfg.reverse_direction;
      result.bridge_enable = 1'b1;
      result.pwm_duty      = speed_next;
    end
  end

endmodule

>>> design/motorized_door_controller.sv
// ----------------------------------------------------------------------------
// motorized_door_controller
// Door motor controller: events in, bridge drive and door status out.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser: opcode; tdata: limit_not_reached, position_value
//  m_axis   | out       | tdata: in1, in2, enable, pwm_duty, door_state, position
//  cfg      | in        | register index and write data, always ready
//
//  One item per cycle while m_axis does not stall; an accepted s_axis item goes
//  through the input register, then the state update feeding the result register.
//  Reset is synchronous and returns the door to closed at position zero.
//  A stalled m_axis holds its item; the input register keeps taking one more.
// ----------------------------------------------------------------------------
module motorized_door_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // limit_not_reached, position_value[23:0]
  input  logic [2:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // in1, in2, enable, pwm_duty[7:0],
                                      // door_state[1:0], position[23:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic               in_valid;
  logic [2:0]         in_opcode;
  logic               in_limit;
  logic signed [23:0] in_position;
  logic               advance;
  logic               out_valid;
  logic [39:0]        out_data;
  mdc_pkg::cfg_t      cfg;
  mdc_pkg::result_t   result;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode   <= s_axis_tuser;
      in_limit    <= s_axis_tdata[0];
      in_position <= s_axis_tdata[24:1];
    end
  end

  mdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mdc_core u_core (
    .clk               (clk),
    .rst               (rst),
    .fire              (advance),
    .opcode            (in_opcode),
    .limit_not_reached (in_limit),
    .position_value    (in_position),
    .cfg               (cfg),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'b000, result.position, result.door_state, result.pwm_duty,
                   result.bridge_enable, result.bridge_in2, result.bridge_in1};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

>>> design/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_checker
// Port-level checks on the door controller result stream.
// ----------------------------------------------------------------------------
module mdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_enable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2] == m_axis_tdata[12])
    else $error("bridge enable does not match moving state");

  a_stopped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |->
      m_axis_tdata[0] && m_axis_tdata[1] && m_axis_tdata[10:3] == 8'd0)
    else $error("stopped door not braked or duty not zero");

  a_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0] != m_axis_tdata[1])
    else $error("moving door with both bridge inputs equal");

endmodule

bind motorized_door_controller mdc_checker u_mdc_checker (.*);
